@@ src/sst_pkg.sv @@
// Shared types and constants for the segmented slot table.
package sst_pkg;

   // Table geometry.
   localparam int TABLE_DEPTH = 1024;
   localparam int IDX_W       = $clog2(TABLE_DEPTH);
   localparam int TOP_W       = IDX_W + 1;
   localparam int HOLE_W      = 10;
   localparam int OBJ_W       = 32;
   localparam int STATUS_W    = 3;

   // Stream widths; the data widths are padded to whole bytes.
   localparam int REQ_DATA_W  = 64;
   localparam int REQ_USER_W  = 1;
   localparam int RSP_DATA_W  = 40;
   localparam int RSP_FIELD_W = STATUS_W + IDX_W + TOP_W + HOLE_W;

   localparam logic [HOLE_W-1:0] HOLES_MAX = {HOLE_W{1'b1}};
   localparam logic [TOP_W-1:0]  TOP_FULL  = TOP_W'(TABLE_DEPTH);

   typedef enum logic {
      OP_ADD    = 1'b0,
      OP_REMOVE = 1'b1
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK       = 3'd0,
      ST_OVERFLOW = 3'd1,
      ST_BELOW    = 3'd2,
      ST_ABOVE    = 3'd3,
      ST_EMPTY    = 3'd4
   } status_type;

   typedef struct packed {
      op_type              operation;
      logic [TOP_W-1:0]    floor_top;
      logic [HOLE_W-1:0]   floor_holes;
      logic [IDX_W-1:0]    entry_index;
      logic [OBJ_W-1:0]    object_ref;
   } req_type;

   typedef struct packed {
      status_type          status;
      logic [IDX_W-1:0]    slot_index;
      logic [TOP_W-1:0]    new_top;
      logic [HOLE_W-1:0]   new_holes;
   } res_type;

   typedef struct packed {
      logic                en;
      logic [IDX_W-1:0]    addr;
      logic [OBJ_W-1:0]    data;
   } mem_wr_type;

   typedef struct packed {
      logic                en;
      logic [IDX_W-1:0]    addr;
   } mem_rd_type;

endpackage

@@ src/sst_ram.sv @@
// Generic simple dual-port RAM with one write port and a registered read port.
module sst_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_q [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_q[wr_addr] <= wr_data;
      end
   end

   // Read port, registered.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_q[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ src/sst_engine.sv @@
// Sequencer that runs add and remove requests against the slot memory.
module sst_engine (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  sst_pkg::req_type       req,
   output logic                   res_valid,
   input  logic                   res_ready,
   output sst_pkg::res_type       res,
   output sst_pkg::mem_wr_type    mem_wr,
   output sst_pkg::mem_rd_type    mem_rd,
   input  logic [sst_pkg::OBJ_W-1:0] mem_rd_data
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_RCHK,
      S_CONSUME,
      S_DONE
   } state_type;

   state_type                       state_ff, state_in;
   logic [sst_pkg::TOP_W-1:0]       top_ff, top_in;
   logic [sst_pkg::HOLE_W-1:0]      holes_ff, holes_in;
   logic [sst_pkg::TOP_W-1:0]       floor_top_ff, floor_top_in;
   logic [sst_pkg::HOLE_W-1:0]      floor_holes_ff, floor_holes_in;
   logic [sst_pkg::IDX_W-1:0]       idx_ff, idx_in;
   logic [sst_pkg::OBJ_W-1:0]       obj_ff, obj_in;
   logic [sst_pkg::IDX_W-1:0]       scan_ff, scan_in;
   logic [sst_pkg::TOP_W-1:0]       t_ff, t_in;
   logic [sst_pkg::HOLE_W-1:0]      left_ff, left_in;
   sst_pkg::res_type                res_ff, res_in;

   // Next-state logic: at most one memory read per cycle, data checked the cycle after.
   always_comb begin
      logic [sst_pkg::TOP_W-1:0]  tt;
      logic [sst_pkg::HOLE_W-1:0] lf;

      tt             = '0;
      lf             = '0;
      state_in       = state_ff;
      top_in         = top_ff;
      holes_in       = holes_ff;
      floor_top_in   = floor_top_ff;
      floor_holes_in = floor_holes_ff;
      idx_in         = idx_ff;
      obj_in         = obj_ff;
      scan_in        = scan_ff;
      t_in           = t_ff;
      left_in        = left_ff;
      res_in         = res_ff;
      mem_wr         = '0;
      mem_rd         = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               floor_top_in   = req.floor_top;
               floor_holes_in = req.floor_holes;
               idx_in         = req.entry_index;
               obj_in         = req.object_ref;
               if (req.operation == sst_pkg::OP_ADD) begin
                  if (top_ff == sst_pkg::TOP_FULL) begin
                     res_in   = '{sst_pkg::ST_OVERFLOW, '0, top_ff, holes_ff};
                     state_in = S_DONE;
                  end else if ((holes_ff > req.floor_holes) &&
                               ({1'b0, top_ff} >= ({1'b0, req.floor_top} +
                                                   (sst_pkg::TOP_W + 1)'(2)))) begin
                     // Segment has holes: search downward from below the top.
                     mem_rd.en   = 1'b1;
                     mem_rd.addr = sst_pkg::IDX_W'(top_ff - sst_pkg::TOP_W'(2));
                     scan_in     = sst_pkg::IDX_W'(top_ff - sst_pkg::TOP_W'(2));
                     state_in    = S_SCAN;
                  end else begin
                     // Push at the top.
                     mem_wr.en   = 1'b1;
                     mem_wr.addr = top_ff[sst_pkg::IDX_W-1:0];
                     mem_wr.data = req.object_ref;
                     top_in      = top_ff + sst_pkg::TOP_W'(1);
                     res_in      = '{sst_pkg::ST_OK, top_ff[sst_pkg::IDX_W-1:0],
                                     top_ff + sst_pkg::TOP_W'(1), holes_ff};
                     state_in    = S_DONE;
                  end
               end else begin
                  if ({1'b0, req.entry_index} < req.floor_top) begin
                     res_in   = '{sst_pkg::ST_BELOW, req.entry_index, top_ff, holes_ff};
                     state_in = S_DONE;
                  end else if ({1'b0, req.entry_index} >= top_ff) begin
                     res_in   = '{sst_pkg::ST_ABOVE, req.entry_index, top_ff, holes_ff};
                     state_in = S_DONE;
                  end else begin
                     mem_rd.en   = 1'b1;
                     mem_rd.addr = req.entry_index;
                     state_in    = S_RCHK;
                  end
               end
            end
         end

         S_SCAN: begin
            if (mem_rd_data == '0) begin
               // Fill the hole that was found.
               mem_wr.en   = 1'b1;
               mem_wr.addr = scan_ff;
               mem_wr.data = obj_ff;
               holes_in    = holes_ff - sst_pkg::HOLE_W'(1);
               res_in      = '{sst_pkg::ST_OK, scan_ff, top_ff,
                               holes_ff - sst_pkg::HOLE_W'(1)};
               state_in    = S_DONE;
            end else if ({1'b0, scan_ff} > floor_top_ff) begin
               mem_rd.en   = 1'b1;
               mem_rd.addr = scan_ff - sst_pkg::IDX_W'(1);
               scan_in     = scan_ff - sst_pkg::IDX_W'(1);
            end else begin
               // No hole in the segment: push at the top instead.
               mem_wr.en   = 1'b1;
               mem_wr.addr = top_ff[sst_pkg::IDX_W-1:0];
               mem_wr.data = obj_ff;
               top_in      = top_ff + sst_pkg::TOP_W'(1);
               res_in      = '{sst_pkg::ST_OK, top_ff[sst_pkg::IDX_W-1:0],
                               top_ff + sst_pkg::TOP_W'(1), holes_ff};
               state_in    = S_DONE;
            end
         end

         S_RCHK: begin
            if (mem_rd_data == '0) begin
               res_in   = '{sst_pkg::ST_EMPTY, idx_ff, top_ff, holes_ff};
               state_in = S_DONE;
            end else begin
               mem_wr.en   = 1'b1;
               mem_wr.addr = idx_ff;
               mem_wr.data = '0;
               state_in    = S_DONE;
               if ({1'b0, idx_ff} == (top_ff - sst_pkg::TOP_W'(1))) begin
                  if (holes_ff > floor_holes_ff) begin
                     // Pop, then swallow empty slots while the segment has holes.
                     tt = top_ff - sst_pkg::TOP_W'(1);
                     lf = holes_ff - floor_holes_ff;
                     if ((tt > floor_top_ff) && (lf != '0)) begin
                        mem_rd.en   = 1'b1;
                        mem_rd.addr = sst_pkg::IDX_W'(tt - sst_pkg::TOP_W'(1));
                        t_in        = tt;
                        left_in     = lf;
                        state_in    = S_CONSUME;
                     end else begin
                        top_in   = tt;
                        holes_in = floor_holes_ff + lf;
                        res_in   = '{sst_pkg::ST_OK, idx_ff, tt, floor_holes_ff + lf};
                     end
                  end else begin
                     top_in = top_ff - sst_pkg::TOP_W'(1);
                     res_in = '{sst_pkg::ST_OK, idx_ff, top_ff - sst_pkg::TOP_W'(1),
                                holes_ff};
                  end
               end else begin
                  // A slot below the top becomes a hole.
                  if (holes_ff != sst_pkg::HOLES_MAX) begin
                     holes_in = holes_ff + sst_pkg::HOLE_W'(1);
                  end
                  res_in = '{sst_pkg::ST_OK, idx_ff, top_ff,
                             (holes_ff != sst_pkg::HOLES_MAX) ?
                             holes_ff + sst_pkg::HOLE_W'(1) : holes_ff};
               end
            end
         end

         S_CONSUME: begin
            if (mem_rd_data != '0) begin
               top_in   = t_ff;
               holes_in = floor_holes_ff + left_ff;
               res_in   = '{sst_pkg::ST_OK, idx_ff, t_ff, floor_holes_ff + left_ff};
               state_in = S_DONE;
            end else begin
               tt = t_ff - sst_pkg::TOP_W'(1);
               lf = left_ff - sst_pkg::HOLE_W'(1);
               if ((tt > floor_top_ff) && (lf != '0)) begin
                  mem_rd.en   = 1'b1;
                  mem_rd.addr = sst_pkg::IDX_W'(tt - sst_pkg::TOP_W'(1));
                  t_in        = tt;
                  left_in     = lf;
               end else begin
                  top_in   = tt;
                  holes_in = floor_holes_ff + lf;
                  res_in   = '{sst_pkg::ST_OK, idx_ff, tt, floor_holes_ff + lf};
                  state_in = S_DONE;
               end
            end
         end

         S_DONE: begin
            if (res_ready) begin
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State, table pointers and latched request fields.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         top_ff   <= '0;
         holes_ff <= '0;
      end else begin
         state_ff <= state_in;
         top_ff   <= top_in;
         holes_ff <= holes_in;
      end
      floor_top_ff   <= floor_top_in;
      floor_holes_ff <= floor_holes_in;
      idx_ff         <= idx_in;
      obj_ff         <= obj_in;
      scan_ff        <= scan_in;
      t_ff           <= t_in;
      left_ff        <= left_in;
      res_ff         <= res_in;
   end

   assign req_ready = (state_ff == S_IDLE);
   assign res_valid = (state_ff == S_DONE);
   assign res       = res_ff;

endmodule

@@ src/segmented_slot_table_with_holes_unit.sv @@
// A push, an overflow or a rejected remove is settled in the idle state; its result is held
// in the engine's result register and then in the output register. An add that searches
// for a hole reads one slot at a time, downward; a remove reads the entry, then the slots
// beneath a popped top. A new item is taken only once the engine has passed on its result.
// Reset clears top and hole count at once; the slot memory needs no clearing pass, since
// only slots below the top are ever read and each of those was written by a push.
module segmented_slot_table_with_holes_unit (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // operation
   input  logic [sst_pkg::REQ_USER_W-1:0]  req_tuser,
   // floor_top, floor_holes, entry_index, object_ref, zero pad
   input  logic [sst_pkg::REQ_DATA_W-1:0]  req_tdata,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // status, slot_index, new_top, new_holes, zero pad
   output logic [sst_pkg::RSP_DATA_W-1:0]  rsp_tdata
);

   sst_pkg::req_type    req;
   sst_pkg::res_type    res;
   sst_pkg::mem_wr_type mem_wr;
   sst_pkg::mem_rd_type mem_rd;
   logic [sst_pkg::OBJ_W-1:0] mem_rd_data;
   logic                res_valid;
   logic                out_free;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [sst_pkg::RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   // Unpack the request item.
   assign req.operation   = sst_pkg::op_type'(req_tuser[0]);
   assign req.floor_top   = req_tdata[10:0];
   assign req.floor_holes = req_tdata[20:11];
   assign req.entry_index = req_tdata[30:21];
   assign req.object_ref  = req_tdata[62:31];

   sst_ram #(
      .WIDTH (sst_pkg::OBJ_W),
      .DEPTH (sst_pkg::TABLE_DEPTH)
   ) u_slots (
      .clock   (clock),
      .wr_en   (mem_wr.en),
      .wr_addr (mem_wr.addr),
      .wr_data (mem_wr.data),
      .rd_en   (mem_rd.en),
      .rd_addr (mem_rd.addr),
      .rd_data (mem_rd_data)
   );

   sst_engine u_engine (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_tvalid),
      .req_ready   (req_tready),
      .req         (req),
      .res_valid   (res_valid),
      .res_ready   (out_free),
      .res         (res),
      .mem_wr      (mem_wr),
      .mem_rd      (mem_rd),
      .mem_rd_data (mem_rd_data)
   );

   // Output register: takes a new result when empty or being drained.
   assign out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (res_valid && out_free) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {(sst_pkg::RSP_DATA_W - sst_pkg::RSP_FIELD_W)'(0),
                         res.new_holes, res.new_top, res.slot_index, res.status};
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule
